/* hw/rtl/u8d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned LEFT_W = 2;

  // Lead byte tags, compared against the top bits of the byte
  localparam logic [2:0] LEAD2_TAG    = 3'h6;
  localparam logic [3:0] LEAD3_TAG    = 4'hE;
  localparam logic [4:0] LEAD4_TAG    = 5'h1E;
  localparam logic [5:0] PAYLOAD_MASK = 6'h3F;
  localparam int unsigned CONT_BIT    = 7;

  // Sequence lengths
  localparam logic [LEN_W-1:0] LEN_IDLE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // One decoded result beat
  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             error;
  } u8d_res_t;

endpackage

/* hw/rtl/u8d_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_in_reg
// Input register: captures one byte beat and holds it until the decode
// stage consumes it.
// ----------------------------------------------------------------------------
module u8d_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
  output logic                      in_stall,
  input  logic                      advance,
  output logic                      held_valid,
  output logic [u8d_pkg::BYTE_W-1:0] held_byte
);
  import u8d_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              take;

  // Hold off the sender only while a held byte cannot move on
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = take || (valid_r && !advance);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

/* hw/rtl/u8d_dec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_dec
// Decode stage: keeps the open-sequence state and, for each byte, updates it
// and flags a result when a sequence completes or fails.
// ----------------------------------------------------------------------------
module u8d_dec (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
  output logic                      res_valid,
  output u8d_pkg::u8d_res_t         res
);
  import u8d_pkg::*;

  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [CP_W-1:0]   accum_r, accum_nxt;
  logic [LEN_W-1:0]  total_r, total_nxt;
  logic [LEFT_W-1:0] left_dec;
  logic [CP_W-1:0]   payload_sh;
  logic [LEN_W-1:0]  used;
  logic              cont;

  assign cont     = byte_in[CONT_BIT];
  assign left_dec = left_r - 2'd1;
  assign used     = total_r - {1'b0, left_r} + LEN_ONE;

  // Place continuation payload by bytes still to come
  always_comb begin
    payload_sh = '0;
    unique case (left_dec)
      2'd0:    payload_sh = {15'd0, byte_in[5:0] & PAYLOAD_MASK};
      2'd1:    payload_sh = {9'd0, byte_in[5:0] & PAYLOAD_MASK, 6'd0};
      2'd2:    payload_sh = {3'd0, byte_in[5:0] & PAYLOAD_MASK, 12'd0};
      default: payload_sh = '0;
    endcase
  end

  // Next state and result
  always_comb begin
    left_nxt       = left_r;
    accum_nxt      = accum_r;
    total_nxt      = total_r;
    res_valid      = 1'b0;
    res.code_point = '0;
    res.seq_length = LEN_ONE;
    res.error      = 1'b0;
    if (left_r == 2'd0) begin
      left_nxt  = 2'd0;
      accum_nxt = '0;
      total_nxt = LEN_IDLE;
      if (!cont) begin
        res_valid      = 1'b1;
        res.code_point = {13'd0, byte_in};
      end else if (byte_in[7:5] == LEAD2_TAG) begin
        accum_nxt = {10'd0, byte_in[4:0], 6'd0};
        left_nxt  = 2'd1;
        total_nxt = LEN_TWO;
      end else if (byte_in[7:4] == LEAD3_TAG) begin
        accum_nxt = {5'd0, byte_in[3:0], 12'd0};
        left_nxt  = 2'd2;
        total_nxt = LEN_THREE;
      end else if (byte_in[7:3] == LEAD4_TAG) begin
        accum_nxt = {byte_in[2:0], 18'd0};
        left_nxt  = 2'd3;
        total_nxt = LEN_FOUR;
      end else begin
        res_valid = 1'b1;
        res.error = 1'b1;
      end
    end else if (!cont) begin
      // Broken sequence: drop the byte, report bytes used
      res_valid      = 1'b1;
      res.error      = 1'b1;
      res.seq_length = used;
      left_nxt       = 2'd0;
      accum_nxt      = '0;
      total_nxt      = LEN_IDLE;
    end else if (left_dec == 2'd0) begin
      res_valid      = 1'b1;
      res.code_point = accum_r | payload_sh;
      res.seq_length = total_r;
      left_nxt       = 2'd0;
      accum_nxt      = '0;
      total_nxt      = LEN_IDLE;
    end else begin
      left_nxt  = left_dec;
      accum_nxt = accum_r | payload_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= 2'd0;
      accum_r <= '0;
      total_r <= LEN_IDLE;
    end else if (step) begin
      left_r  <= left_nxt;
      accum_r <= accum_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

/* hw/rtl/u8d_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result register: holds one result beat until the receiver takes it and
// tells the decode stage when it may step.
// ----------------------------------------------------------------------------
module u8d_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  u8d_pkg::u8d_res_t             res,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u8d_pkg::CP_W-1:0]      out_code_point,
  output logic [u8d_pkg::LEN_W-1:0]     out_seq_length,
  output logic                          out_error
);
  import u8d_pkg::*;

  logic     valid_r, valid_nxt;
  u8d_res_t res_r;

  // Free when empty or the held beat leaves this cycle
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_point = res_r.code_point;
  assign out_seq_length = res_r.seq_length;
  assign out_error      = res_r.error;

endmodule

/* hw/rtl/utf8_byte_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// Decodes a UTF-8 byte stream into code points, one byte beat per cycle while out_stall stays low.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one raw byte (in_byte) per beat.
// Result channel: out_valid / out_stall carry out_code_point, out_seq_length
// and out_error. A result appears for every single-byte character, every
// completed multi-byte sequence and every error (bad lead byte, or a
// continuation byte with bit 7 clear, which is dropped).
// Throughput: one byte per cycle, sustained while out_stall stays low.
// The input register captures the byte completing or breaking its sequence,
// then the decode stage writes its result into the result register, which
// raises out_valid.
// Reset (rst_n low, synchronous): both stage registers empty, decoder idle
// awaiting a lead byte.
// Stall: a held result waits in the result register; the decode stage stops
// and in_stall rises once the input register is also occupied, so no byte
// is lost or repeated.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [u8d_pkg::CP_W-1:0]  out_code_point,
  output logic [u8d_pkg::LEN_W-1:0] out_seq_length,
  output logic                      out_error
);
  import u8d_pkg::*;

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              free;
  logic              step;
  logic              res_valid;
  u8d_res_t          res;

  // Decode advances when a byte is held and the result slot is free
  assign step = held_valid && free;

  u8d_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_stall   (in_stall),
    .advance    (free),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  u8d_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  u8d_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (step && res_valid),
    .res            (res),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_seq_length (out_seq_length),
    .out_error      (out_error)
  );

endmodule
